>>> rtl/weighted_fixed_window_flood_limiter_defines.svh
// ----------------------------------------------------------------------------
// Weighted fixed window flood limiter assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_FIXED_WINDOW_FLOOD_LIMITER_DEFINES_SVH
`define WEIGHTED_FIXED_WINDOW_FLOOD_LIMITER_DEFINES_SVH

`ifndef SYNTH
`define WFL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
`define WFL_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);
`else
`define WFL_ASSERT(lbl, clk, rst, prop, msg)
`define WFL_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/wflim_pkg.sv
// ----------------------------------------------------------------------------
// Flood limiter package
// Field widths, register indexes, message type codes and the result word.
// ----------------------------------------------------------------------------
package wflim_pkg;

   localparam int unsigned NOW_W    = 32;
   localparam int unsigned SLOT_W   = 8;
   localparam int unsigned TYPE_W   = 2;
   localparam int unsigned WEIGHT_W = 16;
   localparam int unsigned CSR_A_W  = 3;
   localparam int unsigned CSR_D_W  = 16;
   localparam int unsigned REQ_D_W  = 48;
   localparam int unsigned RSP_D_W  = 8;

   localparam logic [CSR_A_W-1:0] CFG_WINDOW_SECONDS = 3'd0;
   localparam logic [CSR_A_W-1:0] CFG_LINE_LIMIT     = 3'd1;
   localparam logic [CSR_A_W-1:0] CFG_BAN_ON_FLOOD   = 3'd2;
   localparam logic [CSR_A_W-1:0] CFG_WEIGHT_PRIVMSG = 3'd3;
   localparam logic [CSR_A_W-1:0] CFG_WEIGHT_NOTICE  = 3'd4;
   localparam logic [CSR_A_W-1:0] CFG_WEIGHT_TAGMSG  = 3'd5;

   localparam logic [TYPE_W-1:0] MSG_ORDINARY = 2'd0;
   localparam logic [TYPE_W-1:0] MSG_NOTICE   = 2'd1;
   localparam logic [TYPE_W-1:0] MSG_TAGMSG   = 2'd2;

   typedef struct packed {
      logic window_restarted;
      logic ban_request;
      logic deny;
   } rsp_flags_type;

endpackage

>>> rtl/wflim_count_ram.sv
// ----------------------------------------------------------------------------
// Flood limiter counter store
// One write and one registered read per cycle, with write-to-read bypass.
// ----------------------------------------------------------------------------
module wflim_count_ram #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned WIDTH = 25
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/weighted_fixed_window_flood_limiter.sv
// ----------------------------------------------------------------------------
// Weighted fixed window flood limiter
// Per-sender weighted message counter with a fixed time window and flood flag.
// ----------------------------------------------------------------------------
// Each word on the req_ channel is one message: time in seconds, sender slot
// and message type. Each message yields exactly one rsp_ word carrying deny,
// ban_request and window_restarted.
// The csr_ port writes the six registers one word per cycle; write it only
// while no message is in flight.
// A message passes the input stage, then the result register. One message is
// taken every cycle while rsp_tready is high: the counter store is read on
// accept and written back when the message leaves the input stage, with a
// bypass for back-to-back messages from one sender. Restarts clear valid bits.
// Reset restores register defaults, empties the pipeline and clears all
// counters; the first message afterwards opens the first window.
// When the receiver holds rsp_tready low the result word is held, one more
// message may enter the input stage, and req_tready then falls.
// ----------------------------------------------------------------------------
`include "weighted_fixed_window_flood_limiter_defines.svh"

module weighted_fixed_window_flood_limiter #(
   parameter int unsigned SENDERS          = 256,
   parameter int unsigned WEIGHT_FRAC_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // now_seconds[31:0], sender_index[39:32], message_type[41:40], zero pad
   input  logic [wflim_pkg::REQ_D_W-1:0]   req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // deny[0], ban_request[1], window_restarted[2], zero pad
   output logic [wflim_pkg::RSP_D_W-1:0]   rsp_tdata,
   input  logic                            csr_we,
   input  logic [wflim_pkg::CSR_A_W-1:0]   csr_addr,
   input  logic [wflim_pkg::CSR_D_W-1:0]   csr_wdata
);

   localparam int unsigned IDX_W   = (SENDERS > 1) ? $clog2(SENDERS) : 1;
   localparam int unsigned COUNT_W = 17 + WEIGHT_FRAC_BITS;
   localparam int unsigned ONE_FIX = 32'd1 << WEIGHT_FRAC_BITS;
   localparam int unsigned FIFTH_FIX = ONE_FIX / 5;
   localparam logic [wflim_pkg::WEIGHT_W-1:0] WEIGHT_ONE   =
      ONE_FIX[wflim_pkg::WEIGHT_W-1:0];
   localparam logic [wflim_pkg::WEIGHT_W-1:0] WEIGHT_FIFTH =
      FIFTH_FIX[wflim_pkg::WEIGHT_W-1:0];

   logic [15:0] window_seconds_ff;
   logic [15:0] line_limit_ff;
   logic        ban_on_flood_ff;
   logic [wflim_pkg::WEIGHT_W-1:0] weight_privmsg_ff;
   logic [wflim_pkg::WEIGHT_W-1:0] weight_notice_ff;
   logic [wflim_pkg::WEIGHT_W-1:0] weight_tagmsg_ff;

   logic                              s1_valid_ff;
   logic [wflim_pkg::NOW_W-1:0]       s1_now_ff;
   logic [wflim_pkg::SLOT_W-1:0]      s1_slot_ff;
   logic [wflim_pkg::TYPE_W-1:0]      s1_type_ff;

   logic [32:0]                       window_end_ff;
   logic                              window_open_ff;
   logic                              count_valid_ff [SENDERS];

   logic                              rsp_valid_ff;
   wflim_pkg::rsp_flags_type          rsp_flags_ff;
   wflim_pkg::rsp_flags_type          rsp_flags_in;

   logic                              req_accept;
   logic                              s1_advance;
   logic                              commit;
   logic [IDX_W-1:0]                  rd_addr;
   logic [IDX_W-1:0]                  s1_addr;
   logic                              s1_in_range;
   logic [COUNT_W-1:0]                rd_count;
   logic [COUNT_W-1:0]                old_count;
   logic [wflim_pkg::WEIGHT_W-1:0]    weight;
   logic [COUNT_W:0]                  sum;
   logic [COUNT_W-1:0]                sat_count;
   logic [COUNT_W-1:0]                limit;
   logic                              restart;
   logic [32:0]                       window_end_in;
   logic                              hit;
   logic                              wr_en;
   logic [COUNT_W-1:0]                wr_data;

   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;
   assign commit     = s1_valid_ff && s1_advance;

   assign rd_addr     = IDX_W'(req_tdata[39:32]);
   assign s1_addr     = IDX_W'(s1_slot_ff);
   assign s1_in_range = 32'(s1_slot_ff) < 32'(SENDERS);

   always_comb begin
      priority if (s1_type_ff == wflim_pkg::MSG_ORDINARY) begin
         weight = weight_privmsg_ff;
      end else if (s1_type_ff == wflim_pkg::MSG_TAGMSG) begin
         weight = weight_tagmsg_ff;
      end else begin
         weight = weight_notice_ff;
      end
   end

   assign restart       = !window_open_ff || ({1'b0, s1_now_ff} > window_end_ff);
   assign window_end_in = {1'b0, s1_now_ff} + 33'(window_seconds_ff);

   assign old_count = (!restart && count_valid_ff[s1_addr]) ? rd_count : '0;
   assign sum       = {1'b0, old_count} + (COUNT_W + 1)'(weight);
   assign sat_count = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
   assign limit     = COUNT_W'(line_limit_ff) << WEIGHT_FRAC_BITS;
   assign hit       = s1_in_range && (sat_count >= limit);

   assign wr_en   = commit && s1_in_range;
   assign wr_data = hit ? '0 : sat_count;

   always_comb begin
      rsp_flags_in.deny             = hit;
      rsp_flags_in.ban_request      = hit && ban_on_flood_ff;
      rsp_flags_in.window_restarted = restart;
   end

   wflim_count_ram #(
      .DEPTH (SENDERS),
      .WIDTH (COUNT_W)
   ) u_count_ram (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_count),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         window_seconds_ff <= 16'd60;
         line_limit_ff     <= 16'd10;
         ban_on_flood_ff   <= 1'b0;
         weight_privmsg_ff <= WEIGHT_ONE;
         weight_notice_ff  <= WEIGHT_ONE;
         weight_tagmsg_ff  <= WEIGHT_FIFTH;
      end else if (csr_we) begin
         unique case (csr_addr)
            wflim_pkg::CFG_WINDOW_SECONDS: window_seconds_ff <= csr_wdata;
            wflim_pkg::CFG_LINE_LIMIT:     line_limit_ff     <= csr_wdata;
            wflim_pkg::CFG_BAN_ON_FLOOD:   ban_on_flood_ff   <= csr_wdata[0];
            wflim_pkg::CFG_WEIGHT_PRIVMSG: weight_privmsg_ff <= csr_wdata;
            wflim_pkg::CFG_WEIGHT_NOTICE:  weight_notice_ff  <= csr_wdata;
            wflim_pkg::CFG_WEIGHT_TAGMSG:  weight_tagmsg_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_now_ff  <= req_tdata[31:0];
         s1_slot_ff <= req_tdata[39:32];
         s1_type_ff <= req_tdata[41:40];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_end_ff  <= '0;
         window_open_ff <= 1'b0;
         for (int i = 0; i < SENDERS; i++) begin
            count_valid_ff[i] <= 1'b0;
         end
      end else if (commit) begin
         if (restart) begin
            window_end_ff  <= window_end_in;
            window_open_ff <= 1'b1;
            for (int i = 0; i < SENDERS; i++) begin
               count_valid_ff[i] <= 1'b0;
            end
         end
         if (s1_in_range) begin
            count_valid_ff[s1_addr] <= !hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(wflim_pkg::RSP_D_W - 3){1'b0}}, rsp_flags_ff};

   `WFL_ASSERT_NORST(a_reset_empties, clock,
      reset |=> (!s1_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")
   `WFL_ASSERT(a_no_overrun, clock, reset,
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready,
      "input stage overrun while result stalled")
   `WFL_ASSERT(a_deny_clears, clock, reset,
      (commit && hit) |=> !count_valid_ff[$past(s1_addr)],
      "denied sender counter still valid")
   `WFL_ASSERT(a_count_kept, clock, reset,
      (commit && s1_in_range && !hit) |=> count_valid_ff[$past(s1_addr)],
      "counted sender lost its valid bit")
   `WFL_ASSERT(a_restart_opens, clock, reset,
      (rsp_valid_ff && rsp_flags_ff.window_restarted) |-> window_open_ff,
      "window restart reported but window not open")

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Flood limiter testbench
// Drives message words at the block and checks every result word, in order,
// against a predictor that keeps its own copy of the registers, the window
// and the per-sender tallies. A short scripted part covers reset behaviour,
// window edges and register extremes. Randomised phases follow, each with
// fresh register settings; all but the last may get bursty gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NOW_W    = wflim_pkg::NOW_W;
   localparam int unsigned SLOT_W   = wflim_pkg::SLOT_W;
   localparam int unsigned TYPE_W   = wflim_pkg::TYPE_W;
   localparam int unsigned WEIGHT_W = wflim_pkg::WEIGHT_W;
   localparam int unsigned CSR_A_W  = wflim_pkg::CSR_A_W;
   localparam int unsigned CSR_D_W  = wflim_pkg::CSR_D_W;
   localparam int unsigned REQ_D_W  = wflim_pkg::REQ_D_W;
   localparam int unsigned RSP_D_W  = wflim_pkg::RSP_D_W;

   localparam int unsigned SENDERS     = 256;
   localparam int unsigned FRAC_BITS   = 8;
   localparam int unsigned COUNT_W     = 17 + FRAC_BITS;
   localparam int unsigned PHASES      = 10;
   localparam int unsigned PHASE_ITEMS = 150;
   localparam int unsigned DRAIN_CYCLES = 8;

   localparam logic [COUNT_W:0] COUNT_MAX = {1'b0, {COUNT_W{1'b1}}};

   localparam logic [TYPE_W-1:0]  MSG_UNASSIGNED  = 2'd3;
   localparam logic [CSR_A_W-1:0] CFG_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_A_W-1:0] CFG_UNMAPPED_HI = 3'd7;

   localparam wflim_pkg::rsp_flags_type F_NONE =
      '{window_restarted: 1'b0, ban_request: 1'b0, deny: 1'b0};
   localparam wflim_pkg::rsp_flags_type F_RESTART =
      '{window_restarted: 1'b1, ban_request: 1'b0, deny: 1'b0};
   localparam wflim_pkg::rsp_flags_type F_DENY_BAN =
      '{window_restarted: 1'b0, ban_request: 1'b1, deny: 1'b1};
   localparam wflim_pkg::rsp_flags_type F_RESTART_DENY_BAN =
      '{window_restarted: 1'b1, ban_request: 1'b1, deny: 1'b1};

   typedef enum logic {ROW_MSG, ROW_WRITE} row_op_type;

   typedef struct packed {
      row_op_type                op;
      logic [CSR_A_W-1:0]        reg_index;
      logic [CSR_D_W-1:0]        reg_value;
      logic [NOW_W-1:0]          now;
      logic [SLOT_W-1:0]         slot;
      logic [TYPE_W-1:0]         kind;
      logic                      typed;
      wflim_pkg::rsp_flags_type  flags;
   } script_row_type;

   localparam int unsigned SCRIPT_ROWS = 33;

   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{ROW_MSG, 3'd0, 16'd0, 32'd0,   8'd0,   wflim_pkg::MSG_ORDINARY, 1'b1, F_RESTART},
      '{ROW_MSG, 3'd0, 16'd0, 32'd60,  8'd0,   wflim_pkg::MSG_ORDINARY, 1'b1, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd60,  8'd0,   wflim_pkg::MSG_NOTICE,   1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd60,  8'd0,   MSG_UNASSIGNED,          1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd60,  8'd0,   wflim_pkg::MSG_TAGMSG,   1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd60,  8'd255, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd60,  8'd0,   wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd60,  8'd0,   wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd60,  8'd0,   wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd60,  8'd0,   wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd60,  8'd0,   wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd60,  8'd0,   wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd61,  8'd0,   wflim_pkg::MSG_ORDINARY, 1'b1, F_RESTART},
      '{ROW_WRITE, wflim_pkg::CFG_WINDOW_SECONDS, 16'd0,
        32'd0, 8'd0, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_WRITE, wflim_pkg::CFG_LINE_LIMIT, 16'd0,
        32'd0, 8'd0, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_WRITE, wflim_pkg::CFG_BAN_ON_FLOOD, 16'd1,
        32'd0, 8'd0, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_WRITE, CFG_UNMAPPED_LO, 16'd0,
        32'd0, 8'd0, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_WRITE, CFG_UNMAPPED_HI, 16'd0,
        32'd0, 8'd0, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd200, 8'd7, wflim_pkg::MSG_ORDINARY, 1'b1,
        F_RESTART_DENY_BAN},
      '{ROW_MSG, 3'd0, 16'd0, 32'd200, 8'd7, wflim_pkg::MSG_TAGMSG, 1'b1, F_DENY_BAN},
      '{ROW_MSG, 3'd0, 16'd0, 32'd201, 8'd7, wflim_pkg::MSG_NOTICE, 1'b1,
        F_RESTART_DENY_BAN},
      '{ROW_WRITE, wflim_pkg::CFG_WINDOW_SECONDS, 16'hFFFF,
        32'd0, 8'd0, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_WRITE, wflim_pkg::CFG_LINE_LIMIT, 16'hFFFF,
        32'd0, 8'd0, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_WRITE, wflim_pkg::CFG_WEIGHT_PRIVMSG, 16'hFFFF,
        32'd0, 8'd0, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd300, 8'd128, wflim_pkg::MSG_ORDINARY, 1'b1, F_RESTART},
      '{ROW_MSG, 3'd0, 16'd0, 32'd300, 8'd128, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_WRITE, wflim_pkg::CFG_LINE_LIMIT, 16'd1,
        32'd0, 8'd0, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_WRITE, wflim_pkg::CFG_WEIGHT_NOTICE, 16'd0,
        32'd0, 8'd0, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_WRITE, wflim_pkg::CFG_WEIGHT_TAGMSG, 16'hFFFF,
        32'd0, 8'd0, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd300, 8'd1,   wflim_pkg::MSG_NOTICE,   1'b1, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd300, 8'd1,   MSG_UNASSIGNED,          1'b1, F_NONE},
      '{ROW_MSG, 3'd0, 16'd0, 32'd300, 8'd1,   wflim_pkg::MSG_TAGMSG,   1'b1, F_DENY_BAN},
      '{ROW_MSG, 3'd0, 16'd0, 32'd300, 8'd128, wflim_pkg::MSG_ORDINARY, 1'b0, F_NONE}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_D_W-1:0]   req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_D_W-1:0]   rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_A_W-1:0]   csr_addr = '0;
   logic [CSR_D_W-1:0]   csr_wdata = '0;

   logic [15:0] cfg_window_seconds = 16'd60;
   logic [15:0] cfg_line_limit     = 16'd10;
   logic        cfg_ban_on_flood   = 1'b0;
   logic [15:0] cfg_weight_privmsg = 16'd256;
   logic [15:0] cfg_weight_notice  = 16'd256;
   logic [15:0] cfg_weight_tagmsg  = 16'd51;

   bit [NOW_W:0]     window_end;
   bit               window_live;
   bit [COUNT_W-1:0] sender_tally [SENDERS];
   bit               tally_live [SENDERS];

   wflim_pkg::rsp_flags_type verdicts_due [$];
   int unsigned   mismatches = 0;
   int unsigned   gap_pct = 0;
   int unsigned   stall_pct = 0;
   int unsigned   stall_left = 0;
   bit            block_idle = 1'b1;

   weighted_fixed_window_flood_limiter #(
      .SENDERS          (SENDERS),
      .WEIGHT_FRAC_BITS (FRAC_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic wflim_pkg::rsp_flags_type judge_message(
         input logic [NOW_W-1:0]  now,
         input logic [SLOT_W-1:0] slot,
         input logic [TYPE_W-1:0] kind);
      wflim_pkg::rsp_flags_type verdict;
      logic [WEIGHT_W-1:0]      weight;
      bit [COUNT_W:0]           total;
      verdict = F_NONE;
      if (!window_live || {1'b0, now} > window_end) begin
         window_live = 1'b1;
         window_end = {1'b0, now} + 33'(cfg_window_seconds);
         foreach (tally_live[i]) tally_live[i] = 1'b0;
         verdict.window_restarted = 1'b1;
      end
      case (kind)
         wflim_pkg::MSG_ORDINARY: weight = cfg_weight_privmsg;
         wflim_pkg::MSG_TAGMSG: weight = cfg_weight_tagmsg;
         default: weight = cfg_weight_notice;
      endcase
      if (32'(slot) < SENDERS) begin
         total = (tally_live[slot] ? {1'b0, sender_tally[slot]} : '0)
                 + (COUNT_W + 1)'(weight);
         if (total > COUNT_MAX) total = COUNT_MAX;
         if (total >= (COUNT_W + 1)'({cfg_line_limit, {FRAC_BITS{1'b0}}})) begin
            verdict.deny = 1'b1;
            verdict.ban_request = cfg_ban_on_flood;
            tally_live[slot] = 1'b0;
            sender_tally[slot] = '0;
         end else begin
            tally_live[slot] = 1'b1;
            sender_tally[slot] = total[COUNT_W-1:0];
         end
      end
      return verdict;
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return WEIGHT_W'($urandom_range(0, 768));
      if (pick < 8) return WEIGHT_W'($urandom);
      if (pick == 8) return '0;
      return '1;
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic write_reg(input logic [CSR_A_W-1:0] index,
                            input logic [CSR_D_W-1:0] value);
      if (!block_idle) begin
         req_tvalid <= 1'b0;
         while (verdicts_due.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
         block_idle = 1'b1;
      end
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         wflim_pkg::CFG_WINDOW_SECONDS: cfg_window_seconds = value;
         wflim_pkg::CFG_LINE_LIMIT: cfg_line_limit = value;
         wflim_pkg::CFG_BAN_ON_FLOOD: cfg_ban_on_flood = value[0];
         wflim_pkg::CFG_WEIGHT_PRIVMSG: cfg_weight_privmsg = value;
         wflim_pkg::CFG_WEIGHT_NOTICE: cfg_weight_notice = value;
         wflim_pkg::CFG_WEIGHT_TAGMSG: cfg_weight_tagmsg = value;
         default: ;
      endcase
   endtask

   task automatic send_message(input logic [NOW_W-1:0] now,
                               input logic [SLOT_W-1:0] slot,
                               input logic [TYPE_W-1:0] kind,
                               input bit typed,
                               input wflim_pkg::rsp_flags_type typed_flags);
      wflim_pkg::rsp_flags_type verdict;
      if (csr_we) csr_we <= 1'b0;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tdata <= {{(REQ_D_W - NOW_W - SLOT_W - TYPE_W){1'b0}}, kind, slot, now};
      req_tvalid <= 1'b1;
      block_idle = 1'b0;
      do @(posedge clock); while (!req_tready);
      verdict = judge_message(now, slot, kind);
      verdicts_due = {verdicts_due, typed ? typed_flags : verdict};
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      wflim_pkg::rsp_flags_type got;
      wflim_pkg::rsp_flags_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = wflim_pkg::rsp_flags_type'(rsp_tdata[2:0]);
         if (verdicts_due.size() == 0) begin
            note_mismatch("result word with no message outstanding");
         end else begin
            want = verdicts_due.pop_front();
            if (got.deny !== want.deny)
               note_mismatch($sformatf("deny %b, expected %b", got.deny, want.deny));
            if (got.ban_request !== want.ban_request)
               note_mismatch($sformatf("ban_request %b, expected %b",
                                       got.ban_request, want.ban_request));
            if (got.window_restarted !== want.window_restarted)
               note_mismatch($sformatf("window_restarted %b, expected %b",
                                       got.window_restarted, want.window_restarted));
         end
      end
   end

   initial begin : stimulus
      int unsigned       pick;
      bit [NOW_W:0]      wall_seconds;
      bit [NOW_W:0]      base;
      logic [SLOT_W-1:0] hot_slots [4];
      logic [SLOT_W-1:0] slot;
      logic [15:0]       win;
      logic [15:0]       lim;
      logic [15:0]       ban;
      logic [15:0]       wp;
      logic [15:0]       wn;
      logic [15:0]       wt;
      int unsigned       gap_choice [4];
      int unsigned       stall_choice [4];
      gap_choice = '{0, 10, 25, 40};
      stall_choice = '{0, 3, 8, 15};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 20;
      stall_pct = 5;
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         if (SCRIPT[i].op == ROW_WRITE)
            write_reg(SCRIPT[i].reg_index, SCRIPT[i].reg_value);
         else
            send_message(SCRIPT[i].now, SCRIPT[i].slot, SCRIPT[i].kind,
                         SCRIPT[i].typed, SCRIPT[i].flags);
      end
      wall_seconds = 33'd300;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               win = 16'd1; lim = 16'd2; ban = 16'd0;
               wp = 16'd0; wn = 16'd256; wt = 16'd1;
            end
            1: begin
               win = 16'hFFFF; lim = 16'hFFFF; ban = 16'hFFFF;
               wp = 16'hFFFF; wn = 16'hFFFF; wt = 16'hFFFF;
            end
            default: begin
               pick = $urandom_range(0, 9);
               if (pick < 3) win = 16'($urandom_range(0, 1));
               else if (pick < 8) win = 16'($urandom_range(2, 20));
               else if (pick < 9) win = 16'($urandom);
               else win = 16'hFFFF;
               pick = $urandom_range(0, 9);
               if (pick < 2) lim = 16'($urandom_range(0, 1));
               else if (pick < 8) lim = 16'($urandom_range(2, 12));
               else if (pick < 9) lim = 16'($urandom);
               else lim = 16'hFFFF;
               ban = 16'($urandom);
               wp = pick_weight();
               wn = pick_weight();
               wt = pick_weight();
            end
         endcase
         if (phase == PHASES - 1) begin
            base = 33'h0_FFFF_FFFF - 33'($urandom_range(0, 40));
            gap_pct = 0;
            stall_pct = 0;
         end else begin
            base = 33'(phase) * 33'h0_1C71_C71C + 33'($urandom_range(0, 1 << 24));
            gap_pct = gap_choice[$urandom_range(0, 3)];
            stall_pct = stall_choice[$urandom_range(0, 3)];
         end
         write_reg(wflim_pkg::CFG_WINDOW_SECONDS, win);
         write_reg(wflim_pkg::CFG_LINE_LIMIT, lim);
         write_reg(wflim_pkg::CFG_BAN_ON_FLOOD, ban);
         write_reg(wflim_pkg::CFG_WEIGHT_PRIVMSG, wp);
         write_reg(wflim_pkg::CFG_WEIGHT_NOTICE, wn);
         write_reg(wflim_pkg::CFG_WEIGHT_TAGMSG, wt);
         if ($urandom_range(0, 2) == 0) write_reg(CFG_UNMAPPED_LO, 16'($urandom));
         if ($urandom_range(0, 2) == 0) write_reg(CFG_UNMAPPED_HI, 16'($urandom));
         if (base > wall_seconds) wall_seconds = base;
         foreach (hot_slots[i]) hot_slots[i] = SLOT_W'($urandom_range(0, 255));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 15);
            if (pick >= 8 && pick < 14)
               wall_seconds += 33'($urandom_range(1, 3));
            else if (pick == 14 && window_end >= wall_seconds)
               wall_seconds = window_end + 33'($urandom_range(0, 1));
            else if (pick == 15)
               wall_seconds += 33'($urandom_range(0, 1 << 20));
            if (wall_seconds > 33'h0_FFFF_FFFF) wall_seconds = 33'h0_FFFF_FFFF;
            if ($urandom_range(0, 15) < 12)
               slot = hot_slots[$urandom_range(0, 3)];
            else
               slot = SLOT_W'($urandom_range(0, 255));
            send_message(wall_seconds[NOW_W-1:0], slot, TYPE_W'($urandom_range(0, 3)),
                         1'b0, F_NONE);
         end
      end
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS weighted_fixed_window_flood_limiter");
      end else begin
         $display("FAIL weighted_fixed_window_flood_limiter");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL weighted_fixed_window_flood_limiter");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/wflim_pkg.sv
rtl/wflim_count_ram.sv
rtl/weighted_fixed_window_flood_limiter.sv
tb/testbench.sv
